>>> sv/spm_pkg.sv
package spm_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int COEF_W      = 32;
  localparam int DEG_W       = 6;
  localparam int TERM_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int FIFO_AW     = $clog2(2 * MAX_TERMS);
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;
  localparam int LVL_W       = FIFO_AW + 1;
  localparam int IN_TDATA_W  = 2 * COEF_W;
  localparam int OUT_TDATA_W = ((COEF_W + DEG_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - COEF_W - DEG_W;

  // Coefficient pair and its degree, broadcast to every cell of the row.
  typedef struct packed {
    logic              valid;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [TERM_W-1:0] term;
  } spm_bcast_t;

  // Per-cycle control of the running-sum chain.
  typedef struct packed {
    logic add;
    logic shift;
  } spm_step_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [DEG_W-1:0]  degree;
    logic              last;
  } spm_result_t;

endpackage

>>> sv/schoolbook_poly_multiply_top.sv
// Flow: each pair is registered into the broadcast register, then into the cells'
// product registers, and its sums are written into the result buffer, which lets a
// product's beats out through its output register once its last pair has been taken.
// Throughput: one input beat per cycle within a product while the result buffer
// has room, and one output beat per cycle while m_tready is high; the next product
// is taken once the row has drained. Synchronous active-high reset, no clearing pass.
module schoolbook_poly_multiply_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spm_pkg::IN_TDATA_W-1:0]  s_tdata,  // coef_first, coef_second
  input  logic                            s_tlast,  // last_term
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spm_pkg::OUT_TDATA_W-1:0] m_tdata,  // product_coef, product_degree, zero pad
  output logic                            m_tlast   // last_result
);
  import spm_pkg::*;

  // The datapath is a row of identical cells. Cell i keeps coefficient pair i and
  // a running sum. When pair t arrives, every cell below t adds both cross
  // products with its own pair and cell t adds the square term, so that cell i
  // then holds the sum of degree t+i. The whole row of sums then shifts down by
  // one cell: the sum leaving cell 0 is final, since no later pair can touch a
  // degree that low, and it is written into the result buffer. After the last
  // pair the row keeps shifting until the upper half of the product has left,
  // which also refills every cell with zero for the next product.

  logic [TERM_W-1:0] terms_seen;
  logic              busy;
  spm_bcast_t        s1;
  logic              s1_last;
  logic              s2_valid;
  logic              s2_last;
  logic [TERM_W-1:0] s2_term;
  logic [TERM_W-1:0] drain_left;
  logic [DEG_W-1:0]  wr_deg;

  logic              in_accept;
  logic              in_final;
  logic              room;
  logic              drain_go;
  logic              wr_final;
  spm_step_t         step;
  spm_result_t       wr_data;
  spm_result_t       out_data;
  logic [LVL_W-1:0]  level;
  logic [COEF_W-1:0] chain [MAX_TERMS+1];

  // A pair is the last of its product when it is marked, or when the row is full.
  assign in_accept = s_tvalid && s_tready;
  assign in_final  = s_tlast || (terms_seen == TERM_W'(MAX_TERMS - 1));

  // Every beat in flight writes one buffer entry, so space is reserved at intake
  // and the pipeline never has to stall.
  assign room = ({1'b0, level} + (LVL_W + 1)'(s1.valid) + (LVL_W + 1)'(s2_valid))
                < (LVL_W + 1)'(FIFO_DEPTH);
  assign s_tready = !busy && room;

  // The drain only moves while the buffer has a free entry.
  assign drain_go   = (drain_left != '0) && (level != LVL_W'(FIFO_DEPTH));
  assign step.add   = s2_valid;
  assign step.shift = s2_valid || drain_go;

  // The highest degree leaves either with the last pair of a single-term
  // product or on the final drain shift.
  assign wr_final = (s2_valid && s2_last && (s2_term == '0))
                 || (drain_go && (drain_left == TERM_W'(1)));

  assign wr_data.coef   = chain[0];
  assign wr_data.degree = wr_deg;
  assign wr_data.last   = wr_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_seen <= '0;
      busy       <= 1'b0;
      s1.valid   <= 1'b0;
      s2_valid   <= 1'b0;
      drain_left <= '0;
      wr_deg     <= '0;
    end else begin
      s1.valid <= in_accept;
      s2_valid <= s1.valid;
      if (in_accept) begin
        terms_seen <= in_final ? '0 : terms_seen + TERM_W'(1);
        s1.coef_a  <= s_tdata[COEF_W-1:0];
        s1.coef_b  <= s_tdata[2*COEF_W-1:COEF_W];
        s1.term    <= terms_seen;
      end
      if (s2_valid && s2_last) begin
        drain_left <= s2_term;
      end else if (drain_go) begin
        drain_left <= drain_left - TERM_W'(1);
      end
      if (step.shift) begin
        wr_deg <= wr_final ? '0 : wr_deg + DEG_W'(1);
      end
      if (step.shift && wr_final) begin
        busy <= 1'b0;
      end
      if (in_accept && in_final) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last <= in_final;
    end
    s2_last <= s1_last;
    s2_term <= s1.term;
  end

  assign chain[MAX_TERMS] = '0;

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    spm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (TERM_W'(g)),
      .bcast    (s1),
      .step     (step),
      .sum_in   (chain[g+1]),
      .sum_out  (chain[g])
    );
  end

  // Finished coefficients wait here; a product is let out only once its last
  // pair has been taken.
  spm_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (step.shift),
    .wr_data     (wr_data),
    .release_inc (in_accept && in_final),
    .level       (level),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (out_data)
  );

  assign m_tdata = {{PAD_W{1'b0}}, out_data.degree, out_data.coef};
  assign m_tlast = out_data.last;

endmodule

>>> sv/spm_cell.sv
module spm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [spm_pkg::TERM_W-1:0] cell_idx,
  input  spm_pkg::spm_bcast_t        bcast,
  input  spm_pkg::spm_step_t         step,
  input  logic [spm_pkg::COEF_W-1:0] sum_in,
  output logic [spm_pkg::COEF_W-1:0] sum_out
);
  import spm_pkg::*;

  logic [COEF_W-1:0] held_a;
  logic [COEF_W-1:0] held_b;
  logic [COEF_W-1:0] prod_a;
  logic [COEF_W-1:0] prod_b;
  logic [COEF_W-1:0] sum;

  // The cell whose index equals the incoming degree keeps the pair and forms
  // the square term; lower cells form both cross products with their pair.
  always_ff @(posedge clk) begin
    if (bcast.valid) begin
      if (bcast.term == cell_idx) begin
        held_a <= bcast.coef_a;
        held_b <= bcast.coef_b;
        prod_a <= bcast.coef_a * bcast.coef_b;
        prod_b <= '0;
      end else if (cell_idx < bcast.term) begin
        prod_a <= bcast.coef_a * held_b;
        prod_b <= bcast.coef_b * held_a;
      end else begin
        prod_a <= '0;
        prod_b <= '0;
      end
    end
  end

  assign sum_out = step.add ? (sum + prod_a + prod_b) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (step.shift) begin
      sum <= sum_in;
    end
  end

endmodule

>>> sv/spm_fifo.sv
module spm_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  spm_pkg::spm_result_t      wr_data,
  input  logic                      release_inc,
  output logic [spm_pkg::LVL_W-1:0] level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spm_pkg::spm_result_t      out_data
);
  import spm_pkg::*;

  spm_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [LVL_W-1:0]   open_cnt;
  logic [LVL_W-1:0]   open_eff;
  logic               rd_en;
  logic               last_taken;

  // A product counts as released once its final input pair is in; the one whose
  // last entry already sits in the output register no longer counts.
  assign last_taken = out_valid && out_ready && out_data.last;
  assign open_eff   = open_cnt - LVL_W'(out_valid && out_data.last);
  assign rd_en      = (level != '0) && (open_eff != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      level     <= '0;
      open_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      wr_ptr   <= wr_ptr + FIFO_AW'(wr_en);
      rd_ptr   <= rd_ptr + FIFO_AW'(rd_en);
      level    <= level + LVL_W'(wr_en) - LVL_W'(rd_en);
      open_cnt <= open_cnt + LVL_W'(release_inc) - LVL_W'(last_taken);
      if (rd_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/spm_checker.sv
module spm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [spm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import spm_pkg::*;

  logic [DEG_W-1:0] exp_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_deg <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_deg <= m_tlast ? '0 : exp_deg + DEG_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_degree_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[COEF_W +: DEG_W] == exp_deg)
    else $error("product degree out of sequence");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:COEF_W+DEG_W] == '0)
    else $error("output padding not zero");

  a_last_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[COEF_W])
    else $error("highest product degree is odd");

  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken straight after the last pair");

endmodule

bind schoolbook_poly_multiply_top spm_checker u_spm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
